// ===== rtl/tcsf_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the two-class selective fifo
// no dependencies

package tcsf_pkg;

    localparam logic       CMD_ENQ     = 1'b0;
    localparam logic       CMD_DEQ     = 1'b1;
    localparam logic       CLASS_PREF  = 1'b1;
    localparam logic [3:0] PRIO_RESET  = 4'd1;
    localparam int         TICKET_W    = 16;
    localparam int         SERVER_W    = 4;

    typedef enum logic [1:0] {
        ST_REMOVED  = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_ACCEPTED = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    load_item;
        logic    wr_tail;
        logic    wr_idx;
        logic    rd_zero;
        logic    idx_clr;
        logic    idx_inc;
        logic    cnt_dec;
        logic    cap_got;
        logic    set_status;
        t_status status;
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_enq;
        logic full;
        logic empty;
        logic srv_match;
        logic rd_pref;
        logic more;
        logic idx_zero;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/tcsf_ram.sv =====
`timescale 1ns / 1ps
// generic single write port ram with registered read
// no dependencies

module tcsf_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/tcsf_ctrl.sv =====
`timescale 1ns / 1ps
// control state machine of the two-class selective fifo
// depends on tcsf_pkg

module tcsf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  tcsf_pkg::t_dp_stat i_stat,
    output tcsf_pkg::t_dp_cmd  o_cmd
);

    tcsf_pkg::t_state r_state;
    tcsf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcsf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcsf_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = tcsf_pkg::S_DISPATCH;
                end
            end
            tcsf_pkg::S_DISPATCH: begin
                if (i_stat.is_enq || i_stat.empty) begin
                    n_state = tcsf_pkg::S_DONE;
                end else begin
                    n_state = tcsf_pkg::S_SCAN;
                end
            end
            tcsf_pkg::S_SCAN: begin
                if (i_stat.srv_match && !i_stat.rd_pref && i_stat.more) begin
                    n_state = tcsf_pkg::S_SCAN;
                end else begin
                    n_state = tcsf_pkg::S_SH_RD;
                end
            end
            tcsf_pkg::S_SH_RD: begin
                if (i_stat.more) begin
                    n_state = tcsf_pkg::S_SH_WR;
                end else begin
                    n_state = tcsf_pkg::S_DONE;
                end
            end
            tcsf_pkg::S_SH_WR: begin
                n_state = tcsf_pkg::S_SH_RD;
            end
            tcsf_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = tcsf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tcsf_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            tcsf_pkg::S_IDLE: begin
                o_in_stall      = 1'b0;
                o_cmd.load_item = i_in_valid;
            end
            tcsf_pkg::S_DISPATCH: begin
                if (i_stat.is_enq) begin
                    o_cmd.set_status = 1'b1;
                    if (i_stat.full) begin
                        o_cmd.status = tcsf_pkg::ST_FULL;
                    end else begin
                        o_cmd.status  = tcsf_pkg::ST_ACCEPTED;
                        o_cmd.wr_tail = 1'b1;
                    end
                end else if (i_stat.empty) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = tcsf_pkg::ST_EMPTY;
                end else begin
                    o_cmd.rd_zero = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                end
            end
            tcsf_pkg::S_SCAN: begin
                o_cmd.cap_got = i_stat.idx_zero || (i_stat.srv_match && i_stat.rd_pref);
                if (i_stat.srv_match && i_stat.rd_pref) begin
                    o_cmd.idx_clr = 1'b0;
                end else if (i_stat.srv_match && i_stat.more) begin
                    o_cmd.idx_inc = 1'b1;
                end else begin
                    // no preferential entry taken: remove the head
                    o_cmd.idx_clr = 1'b1;
                end
            end
            tcsf_pkg::S_SH_RD: begin
                if (!i_stat.more) begin
                    o_cmd.cnt_dec    = 1'b1;
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = tcsf_pkg::ST_REMOVED;
                end
            end
            tcsf_pkg::S_SH_WR: begin
                o_cmd.wr_idx  = 1'b1;
                o_cmd.idx_inc = 1'b1;
            end
            tcsf_pkg::S_DONE: begin
                o_cmd.load_out = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/tcsf_dp.sv =====
`timescale 1ns / 1ps
// datapath: entry store, count, scan index, request and result registers
// depends on tcsf_pkg and tcsf_ram

module tcsf_dp #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TICKET_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [tcsf_pkg::SERVER_W-1:0] i_cfg_wr_data,
    input  logic                          i_cmd,
    input  logic                          i_entry_class,
    input  logic [tcsf_pkg::TICKET_W-1:0] i_ticket,
    input  logic [tcsf_pkg::SERVER_W-1:0] i_server_id,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic                          o_served_class,
    output logic [tcsf_pkg::TICKET_W-1:0] o_served_ticket,
    output logic [tcsf_pkg::SERVER_W-1:0] o_served_server,
    input  tcsf_pkg::t_dp_cmd             i_dp_cmd,
    output tcsf_pkg::t_dp_stat            o_dp_stat
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = TICKET_BITS + 1;

    logic [tcsf_pkg::SERVER_W-1:0] r_prio;
    logic                          r_cmd;
    logic                          r_cls;
    logic [TICKET_BITS-1:0]        r_tk;
    logic [tcsf_pkg::SERVER_W-1:0] r_srv;
    logic [CW-1:0]                 r_count;
    logic [AW-1:0]                 r_idx;
    logic [EW-1:0]                 r_got;
    tcsf_pkg::t_status             r_res;
    logic                          r_out_valid;
    logic [1:0]                    r_out_status;
    logic                          r_out_class;
    logic [tcsf_pkg::TICKET_W-1:0] r_out_ticket;
    logic [tcsf_pkg::SERVER_W-1:0] r_out_server;

    logic [31:0]     tk_in32;
    logic [31:0]     got_tk32;
    logic [CW-1:0]   idx_next;
    logic            ram_wr_en;
    logic [AW-1:0]   ram_wr_addr;
    logic [EW-1:0]   ram_wr_data;
    logic [AW-1:0]   ram_rd_addr;
    logic [EW-1:0]   ram_rd_data;

    assign tk_in32  = 32'(i_ticket);
    assign got_tk32 = 32'(r_got[TICKET_BITS-1:0]);
    assign idx_next = CW'(r_idx) + CW'(1);

    always_comb begin
        ram_wr_en   = i_dp_cmd.wr_tail || i_dp_cmd.wr_idx;
        ram_wr_addr = r_idx;
        ram_wr_data = ram_rd_data;
        if (i_dp_cmd.wr_tail) begin
            ram_wr_addr = r_count[AW-1:0];
            ram_wr_data = {r_cls, r_tk};
        end
        ram_rd_addr = i_dp_cmd.rd_zero ? '0 : idx_next[AW-1:0];
    end

    tcsf_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio      <= tcsf_pkg::PRIO_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_prio <= i_cfg_wr_data;
            end
            if (i_dp_cmd.wr_tail) begin
                r_count <= r_count + CW'(1);
            end else if (i_dp_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_dp_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load_item) begin
            r_cmd <= i_cmd;
            r_cls <= i_entry_class;
            r_tk  <= tk_in32[TICKET_BITS-1:0];
            r_srv <= i_server_id;
        end
        if (i_dp_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_dp_cmd.idx_inc) begin
            r_idx <= idx_next[AW-1:0];
        end
        if (i_dp_cmd.cap_got) begin
            r_got <= ram_rd_data;
        end
        if (i_dp_cmd.set_status) begin
            r_res <= i_dp_cmd.status;
        end
        if (i_dp_cmd.load_out) begin
            r_out_status <= r_res;
            if (r_res == tcsf_pkg::ST_REMOVED) begin
                r_out_class  <= r_got[EW-1];
                r_out_ticket <= got_tk32[tcsf_pkg::TICKET_W-1:0];
                r_out_server <= r_srv;
            end else begin
                r_out_class  <= 1'b0;
                r_out_ticket <= '0;
                r_out_server <= '0;
            end
        end
    end

    always_comb begin
        o_dp_stat.is_enq    = (r_cmd == tcsf_pkg::CMD_ENQ);
        o_dp_stat.full      = (r_count == CW'(QUEUE_DEPTH));
        o_dp_stat.empty     = (r_count == '0);
        o_dp_stat.srv_match = (r_srv == r_prio);
        o_dp_stat.rd_pref   = (ram_rd_data[EW-1] == tcsf_pkg::CLASS_PREF);
        o_dp_stat.more      = (idx_next < r_count);
        o_dp_stat.idx_zero  = (r_idx == '0);
        o_dp_stat.out_free  = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_served_class  = r_out_class;
    assign o_served_ticket = r_out_ticket;
    assign o_served_server = r_out_server;

endmodule

// ===== rtl/two_class_selective_fifo.sv =====
`timescale 1ns / 1ps
// top level of the two-class selective fifo: controller plus datapath
// depends on tcsf_pkg, tcsf_ctrl, tcsf_dp

// Ordered queue of up to QUEUE_DEPTH entries (class bit and ticket) held in one
// registered-read ram. Every request gives exactly one result through an output
// register, so a new request is taken while the previous result waits. One request
// is worked at a time: an enqueue, a full drop or an empty dequeue passes the
// dispatch and done states before its result is loaded. A dequeue passes dispatch,
// a scan that reads s entries (1 for a normal server, up to the fill for the
// priority server), a shift of the m entries behind the removed one, each moved
// forward by one read and one write of the single ram port pair, and done. The
// next request is accepted in the cycle after the result is loaded, and a result
// still held by the receiver delays the load of the following one.
// After reset the queue is empty and the priority server is 1.

module two_class_selective_fifo #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TICKET_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [tcsf_pkg::SERVER_W-1:0] i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_cmd,
    input  logic                          i_entry_class,
    input  logic [tcsf_pkg::TICKET_W-1:0] i_ticket,
    input  logic [tcsf_pkg::SERVER_W-1:0] i_server_id,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic                          o_served_class,
    output logic [tcsf_pkg::TICKET_W-1:0] o_served_ticket,
    output logic [tcsf_pkg::SERVER_W-1:0] o_served_server
);

    tcsf_pkg::t_dp_cmd  dp_cmd;
    tcsf_pkg::t_dp_stat dp_stat;

    tcsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    tcsf_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TICKET_BITS (TICKET_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_cmd           (i_cmd),
        .i_entry_class   (i_entry_class),
        .i_ticket        (i_ticket),
        .i_server_id     (i_server_id),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_served_class  (o_served_class),
        .o_served_ticket (o_served_ticket),
        .o_served_server (o_served_server),
        .i_dp_cmd        (dp_cmd),
        .o_dp_stat       (dp_stat)
    );

endmodule
